>>> rtl/smx_pkg.sv
// Package for the stack machine execute unit: opcodes, error and status
// codes, sequencer states and the request/response types of the shared ALU.
// No dependencies.
`default_nettype none

package smx_pkg;

  // Stream widths, padded to whole bytes
  localparam int IN_W  = 72;  // 5 + 32 + 32 + 2 = 71
  localparam int OUT_W = 72;  // 2 + 4 + 1 + 16 + 3 + 32 + 7 = 65

  // Opcodes
  localparam logic [4:0] OP_PUSH         = 5'd0;
  localparam logic [4:0] OP_STORE        = 5'd1;
  localparam logic [4:0] OP_LOAD         = 5'd2;
  localparam logic [4:0] OP_SETLINE      = 5'd3;
  localparam logic [4:0] OP_JUMP         = 5'd4;
  localparam logic [4:0] OP_JUMPIF       = 5'd5;
  localparam logic [4:0] OP_HALT         = 5'd6;
  localparam logic [4:0] OP_LINE         = 5'd7;
  localparam logic [4:0] OP_PRINT_INT    = 5'd8;
  localparam logic [4:0] OP_PRINT_INT_NL = 5'd9;
  localparam logic [4:0] OP_PRINT_STR    = 5'd10;
  localparam logic [4:0] OP_PRINT_STR_NL = 5'd11;
  localparam logic [4:0] OP_READ         = 5'd12;
  localparam logic [4:0] OP_ADD          = 5'd13;
  localparam logic [4:0] OP_SUB          = 5'd14;
  localparam logic [4:0] OP_MUL          = 5'd15;
  localparam logic [4:0] OP_DIV          = 5'd16;
  localparam logic [4:0] OP_MOD          = 5'd17;
  localparam logic [4:0] OP_EQ           = 5'd18;
  localparam logic [4:0] OP_NE           = 5'd19;
  localparam logic [4:0] OP_GT           = 5'd20;
  localparam logic [4:0] OP_LT           = 5'd21;
  localparam logic [4:0] OP_GE           = 5'd22;
  localparam logic [4:0] OP_LE           = 5'd23;
  localparam logic [4:0] OP_FIRST_BAD    = 5'd24;

  // Error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_OVERFLOW  = 4'd1;
  localparam logic [3:0] ERR_UNDERFLOW = 4'd2;
  localparam logic [3:0] ERR_ADDRESS   = 4'd3;
  localparam logic [3:0] ERR_JUMP      = 4'd4;
  localparam logic [3:0] ERR_DIVZERO   = 4'd5;
  localparam logic [3:0] ERR_EOF       = 4'd6;
  localparam logic [3:0] ERR_LITERAL   = 4'd7;
  localparam logic [3:0] ERR_OPCODE    = 4'd8;

  // Run status
  localparam logic [1:0] RUN_CONTINUE = 2'd0;
  localparam logic [1:0] RUN_HALTED   = 2'd1;
  localparam logic [1:0] RUN_ERROR    = 2'd2;

  // Read status
  localparam logic [1:0] RD_OK  = 2'd0;
  localparam logic [1:0] RD_EOF = 2'd1;

  // Print kinds
  localparam logic [2:0] PK_NONE = 3'd0;

  // Configuration register indexes
  localparam logic [1:0] CFG_MEM_WORDS   = 2'd0;
  localparam logic [1:0] CFG_STACK_WORDS = 2'd1;
  localparam logic [1:0] CFG_CODE_LINES  = 2'd2;

  // Sequencer of the top level
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_POP1, S_POP2, S_EXEC, S_LOAD, S_ALU, S_FIN
  } seq_state_t;

  // Shared ALU sequencer
  typedef enum logic [1:0] {
    A_IDLE, A_DIV, A_FIX
  } alu_state_t;

  typedef struct packed {
    logic       start;
    logic [4:0] op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

  // Stack entries an opcode pops
  function automatic logic [1:0] pops_needed(input logic [4:0] op);
    logic [1:0] n;
    case (op)
      OP_STORE, OP_JUMPIF:                         n = 2'd2;
      OP_LOAD, OP_JUMP, OP_PRINT_INT,
      OP_PRINT_INT_NL, OP_READ:                    n = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE:    n = 2'd2;
      default:                                     n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/smx_alu.sv
// Shared ALU: add, sub, mul and compares with a registered result, signed
// divide and modulo by a radix-2 restoring loop (32 steps plus a sign fix).
// Depends on smx_pkg.
`default_nettype none

module smx_alu (
  input  wire                logic clk,
  input  wire                logic rst,
  input  smx_pkg::alu_req_t  req,
  input  wire                logic [31:0] p,
  input  wire                logic [31:0] q,
  output smx_pkg::alu_rsp_t  rsp
);
  import smx_pkg::*;

  alu_state_t  state, state_next;
  logic [4:0]  op_r;
  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        p_neg, q_neg;
  logic [31:0] result;
  logic        done;

  logic        is_div;
  logic [31:0] quick;
  logic [32:0] rem_sh, diff;
  logic        take;

  assign is_div = (req.op == OP_DIV) || (req.op == OP_MOD);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      A_IDLE:  if (req.start && is_div) state_next = A_DIV;
      A_DIV:   if (cnt == 5'd31) state_next = A_FIX;
      A_FIX:   state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  // Quick operations and one divide step
  always_comb begin
    case (req.op)
      OP_ADD:  quick = p + q;
      OP_SUB:  quick = p - q;
      OP_MUL:  quick = p * q;
      OP_EQ:   quick = {31'b0, p == q};
      OP_NE:   quick = {31'b0, p != q};
      OP_GT:   quick = {31'b0, $signed(q) < $signed(p)};
      OP_LT:   quick = {31'b0, $signed(p) < $signed(q)};
      OP_GE:   quick = {31'b0, !($signed(p) < $signed(q))};
      OP_LE:   quick = {31'b0, !($signed(q) < $signed(p))};
      default: quick = 32'd0;
    endcase
    rem_sh = {rem[31:0], quo[31]};
    diff   = rem_sh - {1'b0, dvs};
    take   = !diff[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        A_IDLE: begin
          done <= req.start && !is_div;
          if (req.start) begin
            if (is_div) begin
              op_r  <= req.op;
              p_neg <= p[31];
              q_neg <= q[31];
              quo   <= p[31] ? (32'd0 - p) : p;
              dvs   <= q[31] ? (32'd0 - q) : q;
              rem   <= 33'd0;
              cnt   <= 5'd0;
            end else begin
              result <= quick;
            end
          end
        end
        A_DIV: begin
          done <= 1'b0;
          rem  <= take ? diff : rem_sh;
          quo  <= {quo[30:0], take};
          cnt  <= cnt + 5'd1;
        end
        A_FIX: begin
          if (op_r == OP_DIV)
            result <= (p_neg ^ q_neg) ? (32'd0 - quo) : quo;
          else
            result <= p_neg ? (32'd0 - rem[31:0]) : rem[31:0];
          done <= 1'b1;
        end
        default: done <= 1'b0;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

`default_nettype wire

>>> rtl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: sequencer, operand stack,
// data memory, configuration registers and output register.
// Depends on smx_pkg and smx_alu.
//
// Usage: one instruction enters per transfer on s_tvalid/s_tready/s_tdata;
// one result leaves per instruction on m_tvalid/m_tready/m_tdata.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, the block does not enforce it. Steps: the
// idle state takes the transfer, then decode, up to 2 stack pops,
// execute, a memory read for a load, the shared ALU for arithmetic and
// compares, with divide and modulo as 32 restoring steps and a sign fix,
// then a finishing state.
// s_tready is high only when the sequencer is idle; one item at a time.
// After reset the data memory is cleared, one word per cycle, for MEM_DEPTH
// words; no item is accepted meanwhile. The stack level resets to zero,
// the line number to one.
// The result sits in an output register; when the receiver stalls the
// next item can still be accepted and runs until its own result is ready,
// then waits until the held result has been taken.
`default_nettype none

module stack_machine_execute_unit #(
  parameter int MEM_DEPTH   = 1024,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  // operation[4:0], immediate[36:5], read_value[68:37], read_status[70:69]
  input  wire logic [smx_pkg::IN_W-1:0]  s_tdata,
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  // run_status[1:0], error_code[5:2], jump_taken[6], jump_line[22:7],
  // print_kind[25:23], print_value[57:26], stack_depth[64:58]
  output      logic [smx_pkg::OUT_W-1:0] m_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [15:0]               cfg_data
);
  import smx_pkg::*;

  localparam int MA = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  seq_state_t state, state_next;

  // Latched instruction
  logic [4:0]  op_r;
  logic [31:0] imm_r, rval_r;
  logic [1:0]  rsts_r;

  // Machine state and working registers
  logic [LW-1:0] level;
  logic [31:0]   line_r;
  logic [31:0]   w1, w2;
  logic [3:0]    err_r;
  logic [1:0]    status_r;
  logic          jt_r;
  logic [15:0]   jl_r;
  logic [2:0]    pk_r;
  logic [31:0]   pv_r;
  logic          push_req;
  logic [31:0]   push_val;
  logic [MA-1:0] clr_addr;

  // Configuration
  logic [10:0] mem_words;
  logic [6:0]  stack_words;
  logic [15:0] code_lines;

  // Memories
  logic [31:0]   stk [STACK_DEPTH];
  logic [31:0]   stk_rdata;
  logic [SA-1:0] stk_raddr, stk_waddr;
  logic          stk_we;
  logic [31:0]   dmem [MEM_DEPTH];
  logic [31:0]   dmem_rdata, dmem_wdata;
  logic [MA-1:0] dmem_raddr, dmem_waddr;
  logic          dmem_we;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Decoded conditions
  logic [1:0]    pops;
  logic [31:0]   mem_lim, stk_cap;
  logic          a1_ok, a2_ok, t1_ok, t2_ok, full, out_free;
  logic          is_arith, div_zero, bad_op, underflow;
  logic [LW-1:0] level_m1, level_m2;
  logic [3:0]    fin_err;
  logic [LW-1:0] fin_level;

  always_comb begin
    pops      = pops_needed(op_r);
    mem_lim   = (32'(mem_words) < 32'(MEM_DEPTH)) ? 32'(mem_words) : 32'(MEM_DEPTH);
    stk_cap   = (32'(stack_words) < 32'(STACK_DEPTH)) ? 32'(stack_words)
                                                       : 32'(STACK_DEPTH);
    a1_ok     = !w1[31] && (w1 < mem_lim);
    a2_ok     = !w2[31] && (w2 < mem_lim);
    t1_ok     = !w1[31] && (w1 != 32'd0) && (w1 < {16'd0, code_lines});
    t2_ok     = !w2[31] && (w2 != 32'd0) && (w2 < {16'd0, code_lines});
    full      = 32'(level) >= stk_cap;
    out_free  = !m_tvalid || m_tready;
    is_arith  = (op_r >= OP_ADD) && (op_r < OP_FIRST_BAD);
    div_zero  = ((op_r == OP_DIV) || (op_r == OP_MOD)) && (w1 == 32'd0);
    bad_op    = op_r >= OP_FIRST_BAD;
    underflow = 32'(level) < 32'(pops);
    level_m1  = level - LW'(1);
    level_m2  = level - LW'(2);
    if (err_r != ERR_NONE)           fin_err = err_r;
    else if (push_req && full)       fin_err = ERR_OVERFLOW;
    else                             fin_err = ERR_NONE;
    if (fin_err != ERR_NONE)         fin_level = '0;
    else if (push_req)               fin_level = level + LW'(1);
    else                             fin_level = level;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == MA'(MEM_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = S_DECODE;
      S_DECODE: begin
        if (bad_op || underflow) state_next = S_FIN;
        else if (pops != 2'd0)   state_next = S_POP1;
        else                     state_next = S_EXEC;
      end
      S_POP1:   state_next = (pops == 2'd2) ? S_POP2 : S_EXEC;
      S_POP2:   state_next = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_LOAD && a1_ok)     state_next = S_LOAD;
        else if (is_arith && !div_zero)   state_next = S_ALU;
        else                              state_next = S_FIN;
      end
      S_LOAD:   state_next = S_FIN;
      S_ALU:    if (alu_rsp.done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    s_tready      = (state == S_IDLE);
    stk_raddr     = (state == S_POP1) ? level_m2[SA-1:0] : level_m1[SA-1:0];
    stk_waddr     = level[SA-1:0];
    stk_we        = (state == S_FIN) && out_free && (fin_err == ERR_NONE) && push_req;
    dmem_raddr    = w1[MA-1:0];
    dmem_we       = 1'b0;
    dmem_waddr    = clr_addr;
    dmem_wdata    = 32'd0;
    case (state)
      S_CLEAR: dmem_we = 1'b1;
      S_EXEC: begin
        if (op_r == OP_STORE && a2_ok) begin
          dmem_we    = 1'b1;
          dmem_waddr = w2[MA-1:0];
          dmem_wdata = w1;
        end else if (op_r == OP_READ && a1_ok && rsts_r == RD_OK) begin
          dmem_we    = 1'b1;
          dmem_waddr = w1[MA-1:0];
          dmem_wdata = rval_r;
        end
      end
      default: ;
    endcase
    alu_req.start = (state == S_EXEC) && is_arith && !div_zero;
    alu_req.op    = op_r;
  end

  // Shared arithmetic unit: binary ops pop q first, then p
  smx_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .p   (w2),
    .q   (w1),
    .rsp (alu_rsp)
  );

  // Operand stack
  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_waddr] <= push_val;
    stk_rdata <= stk[stk_raddr];
  end

  // Data memory
  always_ff @(posedge clk) begin
    if (dmem_we) dmem[dmem_waddr] <= dmem_wdata;
    dmem_rdata <= dmem[dmem_raddr];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      level       <= '0;
      line_r      <= 32'd1;
      mem_words   <= 11'd1024;
      stack_words <= 7'd64;
      code_lines  <= 16'd1;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEM_WORDS:   mem_words   <= cfg_data[10:0];
          CFG_STACK_WORDS: stack_words <= cfg_data[6:0];
          CFG_CODE_LINES:  code_lines  <= cfg_data;
          default: ;
        endcase
      end

      // output register drains unless a new result is loaded
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;

      case (state)
        S_CLEAR: clr_addr <= clr_addr + MA'(1);
        S_IDLE: begin
          if (s_tvalid) begin
            op_r     <= s_tdata[4:0];
            imm_r    <= s_tdata[36:5];
            rval_r   <= s_tdata[68:37];
            rsts_r   <= s_tdata[70:69];
            err_r    <= ERR_NONE;
            status_r <= RUN_CONTINUE;
            jt_r     <= 1'b0;
            jl_r     <= 16'd0;
            pk_r     <= PK_NONE;
            pv_r     <= 32'd0;
            push_req <= 1'b0;
          end
        end
        S_DECODE: begin
          if (bad_op)         err_r <= ERR_OPCODE;
          else if (underflow) err_r <= ERR_UNDERFLOW;
        end
        S_POP1: w1 <= stk_rdata;
        S_POP2: w2 <= stk_rdata;
        S_EXEC: begin
          level <= level - LW'(pops);
          case (op_r)
            OP_PUSH: begin
              push_req <= 1'b1;
              push_val <= imm_r;
            end
            OP_STORE: if (!a2_ok) err_r <= ERR_ADDRESS;
            OP_LOAD: begin
              if (!a1_ok) err_r <= ERR_ADDRESS;
              else        push_req <= 1'b1;
            end
            OP_SETLINE: line_r <= imm_r;
            OP_JUMP: begin
              if (!t1_ok) err_r <= ERR_JUMP;
              else begin
                jt_r <= 1'b1;
                jl_r <= w1[15:0];
              end
            end
            OP_JUMPIF: begin
              if (!t2_ok) err_r <= ERR_JUMP;
              else if (w1 != 32'd0) begin
                jt_r <= 1'b1;
                jl_r <= w2[15:0];
              end
            end
            OP_HALT: status_r <= RUN_HALTED;
            OP_LINE: begin
              push_req <= 1'b1;
              push_val <= line_r + 32'd1;
            end
            OP_PRINT_INT, OP_PRINT_INT_NL: begin
              pv_r <= w1;
              pk_r <= 3'(op_r - OP_LINE);
            end
            OP_PRINT_STR, OP_PRINT_STR_NL: pk_r <= 3'(op_r - OP_LINE);
            OP_READ: begin
              if (!a1_ok)                err_r <= ERR_ADDRESS;
              else if (rsts_r == RD_EOF) err_r <= ERR_EOF;
              else if (rsts_r != RD_OK)  err_r <= ERR_LITERAL;
            end
            default: begin
              if (div_zero)      err_r <= ERR_DIVZERO;
              else if (is_arith) push_req <= 1'b1;
            end
          endcase
        end
        S_LOAD: push_val <= dmem_rdata;
        S_ALU:  if (alu_rsp.done) push_val <= alu_rsp.result;
        S_FIN: begin
          if (out_free) begin
            level    <= fin_level;
            m_tvalid <= 1'b1;
            if (fin_err != ERR_NONE)
              m_tdata <= {7'd0, 7'd0, 32'd0, PK_NONE, 16'd0, 1'b0, fin_err, RUN_ERROR};
            else
              m_tdata <= {7'd0, 7'(fin_level), pv_r, pk_r, jl_r, jt_r, ERR_NONE, status_r};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/smx_checker.sv
// Port-level checker for the stack machine execute unit, bound to the top.
// Depends on smx_pkg and stack_machine_execute_unit.
`default_nettype none

module smx_port_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [smx_pkg::OUT_W-1:0] m_tdata
);
  import smx_pkg::*;

  // nothing to send right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // input ready drops right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // an error empties the stack and clears print and jump
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == RUN_ERROR) |->
      (m_tdata[64:58] == 7'd0) && (m_tdata[25:23] == PK_NONE) && !m_tdata[6])
    else $error("error result not cleaned");

  // error code and run status agree
  a_err_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[5:2] != ERR_NONE) == (m_tdata[1:0] == RUN_ERROR)))
    else $error("error code and run status disagree");

endmodule

bind stack_machine_execute_unit smx_port_checker u_smx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/smx_checker.sv
// Result checker for the stack machine execute unit: watches both stream
// channels and the configuration port, predicts each result, compares.
// Depends on smx_pkg.
`timescale 1ns / 100ps

module smx_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [smx_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [smx_pkg::OUT_W-1:0] m_tdata,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data,
  output int                        fail_count,
  output int                        pending_results
);
  import smx_pkg::*;

  localparam int MEMD = 1024;
  localparam int STKD = 64;

  logic [31:0] opstack [STKD];
  logic [31:0] dmem [MEMD];
  logic [6:0]  level;
  logic [31:0] cur_line;
  logic [10:0] mem_words;
  logic [6:0]  stack_words;
  logic [15:0] code_lines;
  logic [64:0] expected_results [$];

  assign pending_results = expected_results.size();

  function automatic logic [1:0] pop_count(input logic [4:0] op);
    case (op)
      OP_STORE, OP_JUMPIF: return 2'd2;
      OP_LOAD, OP_JUMP, OP_PRINT_INT, OP_PRINT_INT_NL, OP_READ: return 2'd1;
      OP_PUSH, OP_SETLINE, OP_HALT, OP_LINE, OP_PRINT_STR, OP_PRINT_STR_NL:
        return 2'd0;
      default: return (op >= OP_FIRST_BAD) ? 2'd0 : 2'd2;
    endcase
  endfunction

  function automatic bit addr_good(input logic [31:0] a);
    int lim;
    lim = (mem_words < MEMD) ? mem_words : MEMD;
    return !a[31] && a < lim;
  endfunction

  function automatic bit target_good(input logic [31:0] t);
    return !t[31] && t >= 1 && t < code_lines;
  endfunction

  // push with capacity check; returns error code
  function automatic logic [3:0] push_word(input logic [31:0] v);
    int cap;
    cap = (stack_words < STKD) ? stack_words : STKD;
    if (level >= cap) return ERR_OVERFLOW;
    opstack[level[5:0]] = v;
    level++;
    return ERR_NONE;
  endfunction

  function automatic logic [31:0] pop_word();
    level--;
    return opstack[level[5:0]];
  endfunction

  // execute one instruction, return packed expected result
  function automatic logic [64:0] execute_instr(input logic [70:0] d);
    logic [4:0]  op;
    logic [31:0] imm, rval, p, q, r, mp, mq;
    logic [1:0]  rsts, status;
    logic [3:0]  err;
    logic        jt;
    logic [15:0] jl;
    logic [2:0]  pk;
    logic [31:0] pv;
    op = d[4:0]; imm = d[36:5]; rval = d[68:37]; rsts = d[70:69];
    status = RUN_CONTINUE; err = ERR_NONE; jt = 0; jl = 0; pk = PK_NONE; pv = 0;
    r = 0;
    if (op < OP_FIRST_BAD && level < pop_count(op)) err = ERR_UNDERFLOW;
    else if (op >= OP_FIRST_BAD) err = ERR_OPCODE;
    else case (op)
      OP_PUSH: err = push_word(imm);
      OP_STORE: begin
        q = pop_word(); p = pop_word();
        if (!addr_good(p)) err = ERR_ADDRESS; else dmem[p[9:0]] = q;
      end
      OP_LOAD: begin
        p = pop_word();
        if (!addr_good(p)) err = ERR_ADDRESS; else err = push_word(dmem[p[9:0]]);
      end
      OP_SETLINE: cur_line = imm;
      OP_JUMP: begin
        q = pop_word();
        if (!target_good(q)) err = ERR_JUMP; else begin jt = 1; jl = q[15:0]; end
      end
      OP_JUMPIF: begin
        p = pop_word(); q = pop_word();
        if (!target_good(q)) err = ERR_JUMP;
        else if (p != 0) begin jt = 1; jl = q[15:0]; end
      end
      OP_HALT: status = RUN_HALTED;
      OP_LINE: err = push_word(cur_line + 32'd1);
      OP_PRINT_INT, OP_PRINT_INT_NL: begin pv = pop_word(); pk = 3'(op - OP_LINE); end
      OP_PRINT_STR, OP_PRINT_STR_NL: pk = 3'(op - OP_LINE);
      OP_READ: begin
        p = pop_word();
        if (!addr_good(p)) err = ERR_ADDRESS;
        else if (rsts == RD_EOF) err = ERR_EOF;
        else if (rsts != RD_OK) err = ERR_LITERAL;
        else dmem[p[9:0]] = rval;
      end
      default: begin
        q = pop_word(); p = pop_word();
        mp = p[31] ? -p : p;
        mq = q[31] ? -q : q;
        case (op)
          OP_ADD: r = p + q;
          OP_SUB: r = p - q;
          OP_MUL: r = p * q;
          OP_DIV, OP_MOD:
            if (q == 0) err = ERR_DIVZERO;
            else if (op == OP_DIV) begin
              r = mp / mq;
              if (p[31] ^ q[31]) r = -r;
            end else begin
              r = mp % mq;
              if (p[31]) r = -r;
            end
          OP_EQ: r = {31'd0, p == q};
          OP_NE: r = {31'd0, p != q};
          OP_GT: r = {31'd0, $signed(p) > $signed(q)};
          OP_LT: r = {31'd0, $signed(p) < $signed(q)};
          OP_GE: r = {31'd0, $signed(p) >= $signed(q)};
          default: r = {31'd0, $signed(p) <= $signed(q)};
        endcase
        if (err == ERR_NONE) err = push_word(r);
      end
    endcase
    if (err != ERR_NONE) begin
      level = 0; status = RUN_ERROR; jt = 0; jl = 0; pk = PK_NONE; pv = 0;
    end
    return {level, pv, pk, jl, jt, err, status};
  endfunction

  // model state, config writes, input prediction and output compare
  always @(posedge clk) begin
    logic [64:0] exp_r;
    if (rst) begin
      foreach (dmem[i]) dmem[i] = 0;
      foreach (opstack[i]) opstack[i] = 0;
      level = 0; cur_line = 1;
      mem_words = 1024; stack_words = 64; code_lines = 1;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MEM_WORDS) mem_words = cfg_data[10:0];
        else if (cfg_index == CFG_STACK_WORDS) stack_words = cfg_data[6:0];
        else if (cfg_index == CFG_CODE_LINES) code_lines = cfg_data;
      end
      if (s_tvalid && s_tready) expected_results.push_back(execute_instr(s_tdata[70:0]));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata[64:0]);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== m_tdata[64:0]) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, m_tdata[64:0]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/tb_top.sv
// Testbench top for the stack machine execute unit: clock, reset, stimulus,
// configuration phases and verdict. Depends on smx_pkg, smx_checker and stack_machine_execute_unit.
`timescale 1ns / 100ps

module tb_top;
  import smx_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               s_tvalid = 0;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 0;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 fail_count, pending_results;
  int                 cycle_count = 0;
  bit                 long_hold = 0;
  int                 sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  stack_machine_execute_unit DUT (.*);

  smx_checker checker_i (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 800000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk iff m_tvalid);
    end
  end

  // valid stays high after a transfer until the next item or an idle wait
  task automatic send_instr(input logic [4:0] op, input logic [31:0] imm,
                            input logic [31:0] rval, input logic [1:0] rsts,
                            input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, rsts, rval, imm, op};
    @(posedge clk iff s_tready);
    sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk iff pending_results == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_word(input int lo_addr);
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, lo_addr);
      default: return $urandom;
    endcase
  endfunction

  // one random instruction, mostly valid stack sequences
  task automatic random_instr(input bit no_gap = 0);
    logic [4:0] op;
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) op = OP_PUSH;
    else if (k < 33) op = 5'($urandom_range(24, 31));
    else op = 5'($urandom_range(1, 23));
    send_instr(op, rand_word(20), $urandom, ($urandom_range(0, 5) == 0) ?
               2'($urandom_range(1, 3)) : RD_OK, no_gap);
  endtask

  initial begin
    logic [4:0] o;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: every opcode, extremes, special cases
    send_instr(OP_PRINT_INT, 0, 0, RD_OK);            // underflow
    wait_idle();
    write_cfg(CFG_CODE_LINES, 16'd100);
    send_instr(OP_PUSH, 32'h8000_0000, 0, RD_OK);
    send_instr(OP_PUSH, 32'hffff_ffff, 0, RD_OK);
    send_instr(OP_DIV, 0, 0, RD_OK);                  // min / -1
    send_instr(OP_PUSH, 32'h8000_0000, 0, RD_OK);
    send_instr(OP_PUSH, 32'hffff_ffff, 0, RD_OK);
    send_instr(OP_MOD, 0, 0, RD_OK);
    send_instr(OP_PUSH, 7, 0, RD_OK);
    send_instr(OP_PUSH, 0, 0, RD_OK);
    send_instr(OP_DIV, 0, 0, RD_OK);                  // divide by zero
    send_instr(OP_PUSH, 5, 0, RD_OK);
    send_instr(OP_READ, 0, 32'h7fff_ffff, 2'd3);      // read status three
    send_instr(OP_PUSH, 200, 0, RD_OK);
    send_instr(OP_PUSH, 0, 0, RD_OK);
    send_instr(OP_JUMPIF, 0, 0, RD_OK);               // bad target, cond zero
    send_instr(OP_SETLINE, 32'h7fff_ffff, 0, RD_OK);
    send_instr(OP_LINE, 0, 0, RD_OK);
    send_instr(OP_PRINT_INT_NL, 0, 0, RD_OK);
    send_instr(OP_HALT, 0, 0, RD_OK);
    send_instr(5'd31, 0, 0, RD_OK);                   // unknown opcode
    for (int i = 0; i < 24; i++) begin
      o = 5'(i);
      send_instr(o, $urandom, $urandom, 2'($urandom_range(0, 2)));
    end
    wait_idle();
    // random phases over several configurations
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_MEM_WORDS, 16'd1); write_cfg(CFG_STACK_WORDS, 16'd1); end
        1: begin write_cfg(CFG_MEM_WORDS, 16'd2047); write_cfg(CFG_STACK_WORDS, 16'd127);
                 write_cfg(CFG_CODE_LINES, 16'd65535); end
        2: begin write_cfg(CFG_MEM_WORDS, 16'd16); write_cfg(CFG_STACK_WORDS, 16'd4);
                 write_cfg(CFG_CODE_LINES, 16'd1); end
        3: begin write_cfg(CFG_MEM_WORDS, 16'd1024); write_cfg(CFG_STACK_WORDS, 16'd64);
                 write_cfg(CFG_CODE_LINES, 16'd30); end
        default: begin
          write_cfg(CFG_MEM_WORDS, 16'($urandom_range(1, 2047)));
          write_cfg(CFG_STACK_WORDS, 16'($urandom_range(1, 127)));
          write_cfg(CFG_CODE_LINES, 16'($urandom_range(1, 65535)));
        end
      endcase
      if (ph == 3) begin
        long_hold = 1;
        for (int i = 0; i < 20; i++) random_instr(1);
      end
      for (int i = 0; i < 240; i++) random_instr(i % 80 < 20);
      wait_idle();
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
